### rtl/core/pvb_pkg.sv
package pvb_pkg;

    localparam int ADDR_W          = 18;
    localparam int OP_W            = 2;
    localparam int CNT_W           = 16;
    localparam int PAGES_PER_BLOCK = 256;
    localparam int NUM_BLOCKS      = 1024;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_QUERY      = 2'd0,
        OP_VALIDATE   = 2'd1,
        OP_INVALIDATE = 2'd2
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [ADDR_W-1:0] page_address;
    } req_t;

    typedef struct packed {
        logic             result_flag;
        logic [CNT_W-1:0] invalid_count;
    } rsp_t;

endpackage

### rtl/core/pvb_stream_if.sv
interface pvb_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/pvb_ram.sv
module pvb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // read-first on a same-address collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### rtl/core/page_valid_bitmap_manager_unit.sv
// Channel   Dir  Payload                        Accepted when
// request   in   opcode, page_address           request.valid && request.ready
// response  out  result_flag, invalid_count     response.valid && response.ready
//
// Two-stage pipeline: accept and row read, then update, write back and result register.
// Throughput one word per cycle unless stalled; a one-row bypass covers back-to-back
// requests to the same block through the single-port-write row memory.
// After reset a clearing pass writes NUM_BLOCKS rows, one per cycle; request.ready stays low.
// A stalled response holds the update stage; request.ready follows its availability.
module page_valid_bitmap_manager_unit #(
    parameter int PAGES_PER_BLOCK = pvb_pkg::PAGES_PER_BLOCK,
    parameter int NUM_BLOCKS      = pvb_pkg::NUM_BLOCKS
) (
    input  logic        clk,
    input  logic        rst_n,
    pvb_stream_if.sink   request,
    pvb_stream_if.source response
);
    localparam int ADDR_W  = pvb_pkg::ADDR_W;
    localparam int CNT_W   = pvb_pkg::CNT_W;
    localparam int BLK_W   = NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1;
    localparam int OFF_W   = $clog2(PAGES_PER_BLOCK);
    localparam int ROW_W   = PAGES_PER_BLOCK + CNT_W;
    localparam int RCP_W   = ADDR_W + 1;
    localparam int PROD_W  = ADDR_W + RCP_W;
    localparam int SHIFT   = ADDR_W + OFF_W;
    localparam longint RCP = ((64'd1 << SHIFT) + PAGES_PER_BLOCK - 1) / PAGES_PER_BLOCK;

    localparam logic [RCP_W-1:0]  RCP_L  = RCP_W'(RCP);
    localparam logic [ADDR_W:0]   NB_L   = (ADDR_W+1)'(NUM_BLOCKS);
    localparam logic [ADDR_W-1:0] PPB_L  = ADDR_W'(PAGES_PER_BLOCK);
    localparam logic [BLK_W-1:0]  LAST_L = BLK_W'(NUM_BLOCKS - 1);

    // stage 0: block number by reciprocal multiply
    logic [PROD_W-1:0] quo_prod;
    logic [ADDR_W-1:0] quo;
    logic              in_fire;
    logic              s1_fire;

    assign quo_prod = {{RCP_W{1'b0}}, request.data.page_address} * {{ADDR_W{1'b0}}, RCP_L};
    assign quo      = ADDR_W'(quo_prod >> SHIFT);
    assign in_fire  = request.valid && request.ready;

    // control
    logic             clearing_reg;
    logic [BLK_W-1:0] clr_idx_reg;
    logic             s1_valid_reg;
    logic             out_valid_reg;

    assign s1_fire       = s1_valid_reg && (!out_valid_reg || response.ready);
    assign request.ready = !clearing_reg && (!s1_valid_reg || s1_fire);

    // stage 1 payload
    pvb_pkg::op_t      s1_op_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [ADDR_W-1:0] s1_quo_reg;
    logic              s1_in_range_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg       <= pvb_pkg::op_t'(request.data.opcode);
            s1_addr_reg     <= request.data.page_address;
            s1_quo_reg      <= quo;
            s1_in_range_reg <= {1'b0, quo} < NB_L;
        end
    end

    // row memory: valid bits in the low part, invalid count on top
    logic             ram_we;
    logic [BLK_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;

    // bypass of the most recent write
    logic             byp_valid_reg;
    logic [BLK_W-1:0] byp_blk_reg;
    logic [ROW_W-1:0] byp_row_reg;

    logic [BLK_W-1:0] s1_blk;
    logic [OFF_W-1:0] s1_off;
    logic [ROW_W-1:0] row_cur;
    logic [ROW_W-1:0] row_new;
    logic             cur_bit;
    logic [CNT_W-1:0] cur_cnt;
    logic             flag_next;
    pvb_pkg::rsp_t    rsp_next;
    logic             s1_write;

    assign s1_blk  = s1_quo_reg[BLK_W-1:0];
    assign s1_off  = OFF_W'(s1_addr_reg - ADDR_W'(s1_quo_reg * PPB_L));
    assign row_cur = (byp_valid_reg && byp_blk_reg == s1_blk) ? byp_row_reg : ram_rdata;
    assign cur_bit = row_cur[s1_off];
    assign cur_cnt = row_cur[ROW_W-1 -: CNT_W];

    always_comb
    begin
        row_new   = row_cur;
        flag_next = 1'b0;
        unique case (s1_op_reg)
            pvb_pkg::OP_QUERY:
            begin
                flag_next = cur_bit;
            end
            pvb_pkg::OP_VALIDATE:
            begin
                if (!cur_bit)
                begin
                    row_new[s1_off] = 1'b1;
                    flag_next       = 1'b1;
                end
            end
            pvb_pkg::OP_INVALIDATE:
            begin
                if (cur_bit)
                begin
                    row_new[s1_off] = 1'b0;
                    flag_next       = 1'b1;
                    if (cur_cnt != pvb_pkg::COUNT_MAX)
                    begin
                        row_new[ROW_W-1 -: CNT_W] = cur_cnt + 1'b1;
                    end
                end
            end
            default:
            begin
                flag_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (s1_in_range_reg)
        begin
            rsp_next.result_flag   = flag_next;
            rsp_next.invalid_count = row_new[ROW_W-1 -: CNT_W];
        end
        else
        begin
            rsp_next.result_flag   = 1'b0;
            rsp_next.invalid_count = '0;
        end
    end

    assign s1_write  = s1_fire && s1_in_range_reg;
    assign ram_we    = clearing_reg || s1_write;
    assign ram_waddr = clearing_reg ? clr_idx_reg : s1_blk;
    assign ram_wdata = clearing_reg ? '0 : row_new;

    pvb_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_BLOCKS)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_fire),
        .raddr (quo[BLK_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_L)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (clearing_reg)
            begin
                byp_valid_reg <= 1'b0;
            end
            else if (s1_write)
            begin
                byp_valid_reg <= 1'b1;
            end
        end
    end

    pvb_pkg::rsp_t out_data_reg;

    always_ff @(posedge clk)
    begin
        if (s1_write)
        begin
            byp_blk_reg <= s1_blk;
            byp_row_reg <= row_new;
        end
        if (s1_fire)
        begin
            out_data_reg <= rsp_next;
        end
    end

    assign response.valid = out_valid_reg;
    assign response.data  = out_data_reg;

    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !request.ready
    ) else $error("request accepted during clearing pass");

    a_clear_covers_all_rows: assert property (
        @(posedge clk) disable iff (!rst_n)
        $fell(clearing_reg) |-> $past(clr_idx_reg) == LAST_L
    ) else $error("clearing pass ended early");

    a_count_monotonic: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_write |-> row_new[ROW_W-1 -: CNT_W] >= cur_cnt
    ) else $error("invalid count decreased");

    a_validate_sets_bit: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_write && s1_op_reg == pvb_pkg::OP_VALIDATE |-> row_new[s1_off]
    ) else $error("validate left page bit clear");

    a_out_of_range_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_fire && !s1_in_range_reg |=>
            response.valid && !response.data.result_flag && response.data.invalid_count == '0
    ) else $error("out of range block gave nonzero result");
endmodule

### tb/tb_page_valid_bitmap_manager_unit.sv
`timescale 1ns / 100ps

module tb_page_valid_bitmap_manager_unit;

    localparam int                        RANDOM_WORDS  = 1100;
    localparam int                        B2B_PAIRS     = 40;
    localparam int                        CYCLE_LIMIT   = 1_000_000;
    localparam int                        HOLD_CYCLES   = 250;
    localparam int                        SAT_BLOCK     = 5;
    localparam logic [pvb_pkg::OP_W-1:0]  OP_UNUSED     = 2'd3;
    localparam int                        TOTAL_PAGES   =
        pvb_pkg::PAGES_PER_BLOCK * pvb_pkg::NUM_BLOCKS;

    class pvb_scoreboard;
        bit                        page_valid [TOTAL_PAGES];
        bit [pvb_pkg::CNT_W-1:0]   block_invalid_cnt [pvb_pkg::NUM_BLOCKS];
        pvb_pkg::rsp_t             rsp_due_q [$];
        int                        errors;

        function void note_request(pvb_pkg::req_t w);
            pvb_pkg::rsp_t exp_rsp;
            int            blk;
            int            page;
            blk  = int'(w.page_address) / pvb_pkg::PAGES_PER_BLOCK;
            page = int'(w.page_address);
            exp_rsp = '0;
            if (blk < pvb_pkg::NUM_BLOCKS)
            begin
                case (w.opcode)
                    pvb_pkg::OP_QUERY:
                        exp_rsp.result_flag = page_valid[page];
                    pvb_pkg::OP_VALIDATE:
                        if (!page_valid[page])
                        begin
                            page_valid[page]    = 1'b1;
                            exp_rsp.result_flag = 1'b1;
                        end
                    pvb_pkg::OP_INVALIDATE:
                        if (page_valid[page])
                        begin
                            page_valid[page] = 1'b0;
                            if (block_invalid_cnt[blk] != pvb_pkg::COUNT_MAX)
                                block_invalid_cnt[blk] = block_invalid_cnt[blk] + 1'b1;
                            exp_rsp.result_flag = 1'b1;
                        end
                    default: ;
                endcase
                exp_rsp.invalid_count = block_invalid_cnt[blk];
            end
            rsp_due_q.push_back(exp_rsp);
        endfunction

        function void check_response(pvb_pkg::rsp_t got);
            pvb_pkg::rsp_t exp_rsp;
            if (rsp_due_q.size() == 0)
            begin
                $display("%0t: response with nothing outstanding: flag %0b count %0d",
                         $time, got.result_flag, got.invalid_count);
                errors++;
                return;
            end
            exp_rsp = rsp_due_q.pop_front();
            if (got.result_flag !== exp_rsp.result_flag)
            begin
                $display("%0t: result_flag expected %0b actual %0b",
                         $time, exp_rsp.result_flag, got.result_flag);
                errors++;
            end
            if (got.invalid_count !== exp_rsp.invalid_count)
            begin
                $display("%0t: invalid_count expected %0d actual %0d",
                         $time, exp_rsp.invalid_count, got.invalid_count);
                errors++;
            end
        endfunction

        function int pending();
            return rsp_due_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    pvb_stream_if #(.payload_t(pvb_pkg::req_t)) request_if ();
    pvb_stream_if #(.payload_t(pvb_pkg::rsp_t)) response_if ();

    page_valid_bitmap_manager_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_if),
        .response (response_if)
    );

    pvb_scoreboard sb = new();

    bit rx_always_ready  = 1'b0;
    bit hold_off_request = 1'b0;
    int cycles           = 0;
    int hot_blocks [3];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_page_valid_bitmap_manager_unit: errors");
            $finish;
        end
    end

    // response side: check, then pick next ready from the current stall pattern
    initial
    begin
        int  rx_mode;
        int  mode_left;
        int  hold_left;
        int  phase;
        bit  hold_done;
        bit  next_ready;
        rx_mode   = 0;
        mode_left = 0;
        hold_left = 0;
        phase     = 0;
        hold_done = 1'b0;
        response_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (response_if.valid && response_if.ready)
                sb.check_response(response_if.data);
            if (hold_off_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            phase++;
            case (rx_mode)
                0:       next_ready = 1'b1;
                1:       next_ready = ($urandom_range(0, 1) == 1);
                2:       next_ready = ($urandom_range(0, 3) == 0);
                default: next_ready = (phase % 3 != 0);
            endcase
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else if (rx_always_ready)
                next_ready = 1'b1;
            response_if.ready <= next_ready;
        end
    end

    task automatic send_word(input logic [pvb_pkg::OP_W-1:0] op,
                             input logic [pvb_pkg::ADDR_W-1:0] addr);
        pvb_pkg::req_t w;
        w.opcode       = op;
        w.page_address = addr;
        request_if.valid <= 1'b1;
        request_if.data  <= w;
        @(posedge clk);
        while (!request_if.ready)
            @(posedge clk);
        sb.note_request(w);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            request_if.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [pvb_pkg::OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return pvb_pkg::OP_QUERY;
        else if (r < 62)
            return pvb_pkg::OP_VALIDATE;
        else if (r < 94)
            return pvb_pkg::OP_INVALIDATE;
        return OP_UNUSED;
    endfunction

    // mostly a few hot blocks and a narrow page window so bits toggle repeatedly
    function automatic logic [pvb_pkg::ADDR_W-1:0] pick_address();
        int r;
        int blk;
        r   = $urandom_range(0, 99);
        blk = hot_blocks[$urandom_range(0, 2)];
        if (r < 60)
            return pvb_pkg::ADDR_W'(blk * pvb_pkg::PAGES_PER_BLOCK + $urandom_range(0, 15));
        else if (r < 75)
            return pvb_pkg::ADDR_W'(blk * pvb_pkg::PAGES_PER_BLOCK
                                    + $urandom_range(0, pvb_pkg::PAGES_PER_BLOCK - 1));
        return pvb_pkg::ADDR_W'($urandom_range(0, (1 << pvb_pkg::ADDR_W) - 1));
    endfunction

    initial
    begin
        int sent;
        int burst;
        request_if.valid = 1'b0;
        request_if.data  = '0;
        rst_n            = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        send_word(pvb_pkg::OP_QUERY, 18'd0);
        send_word(pvb_pkg::OP_VALIDATE, 18'd0);
        send_word(pvb_pkg::OP_VALIDATE, 18'd0);
        send_word(pvb_pkg::OP_QUERY, 18'd0);
        send_word(pvb_pkg::OP_INVALIDATE, 18'd0);
        send_word(pvb_pkg::OP_INVALIDATE, 18'd0);
        send_word(pvb_pkg::OP_VALIDATE, 18'd0);
        send_word(OP_UNUSED, 18'd0);
        send_word(pvb_pkg::OP_QUERY, 18'd0);
        send_word(pvb_pkg::OP_VALIDATE, 18'h3FFFF);
        send_word(pvb_pkg::OP_QUERY, 18'h3FFFF);
        send_word(pvb_pkg::OP_INVALIDATE, 18'h3FFFF);
        send_word(OP_UNUSED, 18'h3FFFF);
        send_word(pvb_pkg::OP_VALIDATE, 18'd255);
        send_word(pvb_pkg::OP_INVALIDATE, 18'd255);
        send_word(pvb_pkg::OP_VALIDATE, 18'd256);
        send_word(OP_UNUSED, 18'd256);
        send_word(pvb_pkg::OP_VALIDATE, 18'h2AAAA);
        send_word(pvb_pkg::OP_VALIDATE, 18'h15555);
        send_word(pvb_pkg::OP_QUERY, 18'h2AAAA);
        send_word(pvb_pkg::OP_INVALIDATE, 18'h15555);
        send_word(pvb_pkg::OP_INVALIDATE, 18'h2AAAA);
        send_word(pvb_pkg::OP_QUERY, 18'h15555);
        idle_gap(3);

        // same block back to back
        rx_always_ready = 1'b1;
        for (int i = 0; i < B2B_PAIRS; i++)
        begin
            send_word(pvb_pkg::OP_VALIDATE,
                      pvb_pkg::ADDR_W'(SAT_BLOCK * pvb_pkg::PAGES_PER_BLOCK
                                       + i % pvb_pkg::PAGES_PER_BLOCK));
            send_word(pvb_pkg::OP_INVALIDATE,
                      pvb_pkg::ADDR_W'(SAT_BLOCK * pvb_pkg::PAGES_PER_BLOCK
                                       + i % pvb_pkg::PAGES_PER_BLOCK));
        end
        idle_gap(2);
        rx_always_ready = 1'b0;

        // random bursts
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            burst = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 16);
            for (int k = 0; k < burst && sent < RANDOM_WORDS; k++)
            begin
                if (sent % 200 == 0)
                begin
                    hot_blocks[0] = SAT_BLOCK;
                    hot_blocks[1] = $urandom_range(0, pvb_pkg::NUM_BLOCKS - 1);
                    hot_blocks[2] = $urandom_range(0, pvb_pkg::NUM_BLOCKS - 1);
                end
                if (sent == 300)
                    hold_off_request = 1'b1;
                send_word(pick_op(), pick_address());
                sent++;
            end
            idle_gap(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6));
        end
        request_if.valid <= 1'b0;

        rx_always_ready = 1'b1;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.errors == 0)
            $display("tb_page_valid_bitmap_manager_unit: clean");
        else
            $display("tb_page_valid_bitmap_manager_unit: errors");
        $finish;
    end

endmodule
